FILE: rtl/ipd_pkg.sv
// Shared types and constants for the IR pulse-distance decoder.
`default_nettype none

package ipd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned KEY_COUNT = 10;

  typedef logic [TIME_W-1:0]       time_t;
  typedef logic [CODE_W-1:0]       code_t;
  typedef logic [DIGIT_W-1:0]      digit_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic signed [IDX_W-1:0] bit_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_START_GAP = 1'd0;
  localparam cfg_idx_t REG_ONE_BIT   = 1'd1;

  localparam time_t START_GAP_RESET = 32'd182000;
  localparam time_t ONE_BIT_RESET   = 32'd30000;

  // Bit index runs from -1 (frame start seen) up to 32 (pattern full)
  localparam bit_idx_t IDX_FULL  = 7'sd32;
  localparam bit_idx_t IDX_START = -7'sd1;
  localparam bit_idx_t IDX_RESET = 7'sd0;

  typedef code_t key_table_t [KEY_COUNT];

  localparam key_table_t KEY_CODES = '{
    32'h00FF6897, 32'h00FF30CF, 32'h00FF18E7, 32'h00FF7A85, 32'h00FF10EF,
    32'h00FF38C7, 32'h00FF5AA5, 32'h00FF42BD, 32'h00FF4AB5, 32'h00FF52AD
  };

  typedef struct packed {
    logic   hit;
    digit_t digit;
  } key_match_t;

endpackage

`default_nettype wire

FILE: rtl/ipd_if.sv
// Valid/ready channel interfaces for capture items and decoded result items.
`default_nettype none

interface ipd_capture_if;
  import ipd_pkg::*;
  logic  valid;
  logic  ready;
  time_t capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface ipd_result_if;
  import ipd_pkg::*;
  logic   valid;
  logic   ready;
  code_t  code_word;
  logic   key_valid;
  digit_t key_digit;

  modport source (output valid, output code_word, output key_valid, output key_digit,
                  input ready);
  modport sink   (input valid, input code_word, input key_valid, input key_digit,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/ipd_key_lookup.sv
// Matches a 32-bit pattern against the ten key codes and returns the digit.
`default_nettype none

module ipd_key_lookup (
  input  ipd_pkg::code_t      pattern,
  output ipd_pkg::key_match_t match
);
  import ipd_pkg::*;

  // Scan from the top so the lowest matching digit wins
  always_comb begin
    match = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (pattern == KEY_CODES[k]) begin
        match.hit   = 1'b1;
        match.digit = DIGIT_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ir_pulse_distance_decoder.sv
// Top level of the IR pulse-distance decoder.
// Each capture item (timer value at a falling IR edge) yields exactly one result item:
// the pattern so far, MSB first, and its key digit when it matches a key code. The
// block takes one capture per clock: the decode state (last edge time, bit index,
// pattern) updates in the cycle an item is accepted, and the result lands in one
// output register, valid in the cycle after acceptance; capture.ready stays high
// unless that register is full and not being taken. Thresholds are raw timer ticks;
// write them only while no item is in flight.
`default_nettype none

module ir_pulse_distance_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  ipd_pkg::cfg_idx_t   cfg_index,
  input  ipd_pkg::time_t      cfg_wdata,
  ipd_capture_if.sink         capture,
  ipd_result_if.source        result
);
  import ipd_pkg::*;

  time_t      start_gap_ticks;
  time_t      one_bit_ticks;
  time_t      last_edge_time;
  code_t      pattern_reg;
  bit_idx_t   bit_index;

  code_t      pattern_next;
  bit_idx_t   bit_index_next;
  bit_idx_t   idx_inc;
  time_t      gap;
  logic       accept;
  key_match_t match;

  logic       out_valid;
  code_t      out_code;
  logic       out_key_valid;
  digit_t     out_key_digit;

  assign capture.ready = !rst && (!out_valid || result.ready);
  assign accept        = capture.valid && capture.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_gap_ticks <= START_GAP_RESET;
      one_bit_ticks   <= ONE_BIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_GAP: start_gap_ticks <= cfg_wdata;
        REG_ONE_BIT:   one_bit_ticks   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Decode step: gap, index advance, start test, bit set
  always_comb begin
    gap            = capture.capture_time - last_edge_time;
    idx_inc        = (bit_index < IDX_FULL) ? bit_index + 7'sd1 : bit_index;
    pattern_next   = pattern_reg;
    bit_index_next = idx_inc;
    if (gap >= start_gap_ticks) begin
      pattern_next   = '0;
      bit_index_next = IDX_START;
    end else if (idx_inc >= 7'sd0 && idx_inc < IDX_FULL && gap >= one_bit_ticks) begin
      pattern_next = pattern_reg | (code_t'(32'h8000_0000) >> idx_inc[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      pattern_reg    <= '0;
      bit_index      <= IDX_RESET;
    end else if (accept) begin
      last_edge_time <= capture.capture_time;
      pattern_reg    <= pattern_next;
      bit_index      <= bit_index_next;
    end
  end

  ipd_key_lookup u_key_lookup (
    .pattern (pattern_next),
    .match   (match)
  );

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_code      <= pattern_next;
      out_key_valid <= match.hit;
      out_key_digit <= match.digit;
    end
  end

  assign result.valid     = out_valid;
  assign result.code_word = out_code;
  assign result.key_valid = out_key_valid;
  assign result.key_digit = out_key_digit;

endmodule

`default_nettype wire

FILE: rtl/ipd_checker.sv
// Port-level checks for the IR pulse-distance decoder, bound to the top level.
`default_nettype none

module ipd_checker (
  input logic                clk,
  input logic                rst,
  input logic                capture_valid,
  input logic                capture_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic                result_key_valid,
  input ipd_pkg::digit_t     result_key_digit
);
  import ipd_pkg::*;

  // An accepted capture always shows a result in the next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    capture_valid && capture_ready |=> result_valid)
    else $error("accepted item produced no result");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> capture_ready)
    else $error("input stalled with empty output");

  // A result that is taken without a new item frees the output
  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !(capture_valid && capture_ready) |=> !result_valid)
    else $error("result repeated after being taken");

  // Digit is zero without a key match and never beyond nine
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_key_valid || result_key_digit == '0) &&
                     result_key_digit <= DIGIT_W'(9))
    else $error("key digit out of range");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind ir_pulse_distance_decoder ipd_checker u_ipd_checker (
  .clk              (clk),
  .rst              (rst),
  .capture_valid    (capture.valid),
  .capture_ready    (capture.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_key_valid (result.key_valid),
  .result_key_digit (result.key_digit)
);

`default_nettype wire
